### src/pnd_pkg.sv
// ----------------------------------------------------------------------------
// pnd_pkg
// Shared constants and types of the pareto non-dominated filter.
// ----------------------------------------------------------------------------
package pnd_pkg;

  localparam int DEF_MAX_POINTS     = 64;
  localparam int DEF_MAX_OBJECTIVES = 4;
  localparam int DEF_VALUE_BITS     = 32;

  // fixed field widths of the stream payloads
  localparam int FIELD_W    = 32;
  localparam int INDEX_W    = 6;
  localparam int NOBJ_W     = 3;
  localparam int MASK_W     = 4;
  localparam int IN_DATA_W  = 4 * FIELD_W;
  localparam int OUT_DATA_W = 136;

  // register indexes of the configuration port
  localparam logic REG_OBJECTIVES = 1'b0;
  localparam logic REG_MIN_MASK   = 1'b1;

  // settings the compare unit works under
  typedef struct packed {
    logic [NOBJ_W-1:0] nobj;
    logic [MASK_W-1:0] minimize;
  } cmp_ctrl_t;

endpackage

### src/pnd_cmp_unit.sv
// ----------------------------------------------------------------------------
// pnd_cmp_unit
// Dominance compare of one candidate point against the point under test.
// ----------------------------------------------------------------------------
module pnd_cmp_unit #(
  parameter int MAX_OBJECTIVES = pnd_pkg::DEF_MAX_OBJECTIVES,
  parameter int VB             = pnd_pkg::FIELD_W
) (
  input  pnd_pkg::cmp_ctrl_t              ctrl,
  input  logic [MAX_OBJECTIVES*VB-1:0]    cur_row,
  input  logic [MAX_OBJECTIVES*VB-1:0]    cand_row,
  output logic                            dominates
);
  import pnd_pkg::*;

  logic [MAX_OBJECTIVES-1:0] worse;
  logic [MAX_OBJECTIVES-1:0] better;

  always_comb begin
    for (int k = 0; k < MAX_OBJECTIVES; k++) begin
      logic signed [VB-1:0] va;
      logic signed [VB-1:0] vb;
      logic                 used;
      logic                 lt;
      logic                 gt;
      va = cur_row[k*VB +: VB];
      vb = cand_row[k*VB +: VB];
      // an objective count of zero still compares the first objective
      used = (k == 0) || (int'(ctrl.nobj) > k);
      lt = vb < va;
      gt = vb > va;
      if (ctrl.minimize[k]) begin
        worse[k]  = used && gt;
        better[k] = used && lt;
      end else begin
        worse[k]  = used && lt;
        better[k] = used && gt;
      end
    end
  end

  assign dominates = (worse == '0) && (better != '0);

endmodule

### src/pareto_non_dominated_filter.sv
// ----------------------------------------------------------------------------
// pareto_non_dominated_filter
// Loads a point set, then emits every point that no other point dominates.
// ----------------------------------------------------------------------------
//  channel   dir   beat content
//  s_*       in    one point: four objective values, tlast closes the set
//  m_*       out   one non-dominated point, tlast on the final one
//  apb       in    objectives_in_use, minimize_mask
//
//  loading accepts one point beat per cycle; after the closing beat
//  s_tready stays low until the last beat and the store of N points is
//  swept pairwise through one compare unit and one memory read port.
//  emission takes a kept point through emit fetch, load and wait, a skipped
//  point through emit fetch alone, and stalls while m_tready is low.
//  reset (rst, synchronous) empties the store and restores the registers.
// ----------------------------------------------------------------------------
module pareto_non_dominated_filter #(
  parameter int MAX_POINTS     = pnd_pkg::DEF_MAX_POINTS,
  parameter int MAX_OBJECTIVES = pnd_pkg::DEF_MAX_OBJECTIVES,
  parameter int VALUE_BITS     = pnd_pkg::DEF_VALUE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // value_0, value_1, value_2, value_3
  input  logic [pnd_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // point_index, out_value_0, out_value_1, out_value_2, out_value_3, zero pad
  output logic [pnd_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tlast,
  // overflow
  output logic                              m_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import pnd_pkg::*;

  localparam int VB     = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
  localparam int ROW_W  = MAX_OBJECTIVES * VB;
  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    ST_LOAD, ST_FETCH, ST_SCAN, ST_DRAIN, ST_EMIT_FETCH, ST_EMIT_LOAD, ST_EMIT_WAIT
  } state_t;

  state_t state;

  logic [NOBJ_W-1:0] objectives_in_use;
  logic [MASK_W-1:0] minimize_mask;

  logic [CNT_W-1:0]      point_count;
  logic                  dropped_flag;
  logic [IDX_W-1:0]      i_idx;
  logic [IDX_W-1:0]      j_idx;
  logic [IDX_W-1:0]      j_prev;
  logic                  pend;
  logic                  cur_load;
  logic                  dom;
  logic [MAX_POINTS-1:0] keep;
  logic [IDX_W-1:0]      last_kept;
  logic [ROW_W-1:0]      cur_row;

  logic [ROW_W-1:0]      point_store [MAX_POINTS];
  logic [ROW_W-1:0]      rd_row;
  logic [IDX_W-1:0]      rd_addr;
  logic [ROW_W-1:0]      wr_row;
  logic                  wr_en;

  logic [ROW_W-1:0]      out_row;
  logic [INDEX_W-1:0]    out_index;
  logic                  out_last;
  logic                  out_ovf;
  logic                  out_valid;

  logic [CNT_W-1:0]      last_idx;
  logic                  cmp_dom;
  logic                  hit;
  logic                  in_beat;
  logic                  out_beat;
  cmp_ctrl_t             ctrl;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      objectives_in_use <= NOBJ_W'(2);
      minimize_mask     <= MASK_W'(15);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_OBJECTIVES: objectives_in_use <= pwdata[NOBJ_W-1:0];
        REG_MIN_MASK:   minimize_mask     <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_OBJECTIVES: prdata = {{(32-NOBJ_W){1'b0}}, objectives_in_use};
      REG_MIN_MASK:   prdata = {{(32-MASK_W){1'b0}}, minimize_mask};
      default:        prdata = '0;
    endcase
  end

  // clamp objective count to what the store holds
  always_comb begin
    ctrl.minimize = minimize_mask;
    if (int'(objectives_in_use) > MAX_OBJECTIVES) begin
      ctrl.nobj = NOBJ_W'(MAX_OBJECTIVES);
    end else begin
      ctrl.nobj = objectives_in_use;
    end
  end

  assign s_tready = (state == ST_LOAD);
  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;
  assign last_idx = point_count - CNT_W'(1);

  // point store
  always_comb begin
    for (int k = 0; k < MAX_OBJECTIVES; k++) begin
      wr_row[k*VB +: VB] = s_tdata[k*FIELD_W +: VB];
    end
  end

  assign wr_en = in_beat && (point_count < CNT_W'(MAX_POINTS));

  always_comb begin
    unique case (state)
      ST_SCAN: rd_addr = j_idx;
      default: rd_addr = i_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      point_store[point_count[IDX_W-1:0]] <= wr_row;
    end
    rd_row <= point_store[rd_addr];
  end

  pnd_cmp_unit #(
    .MAX_OBJECTIVES(MAX_OBJECTIVES),
    .VB(VB)
  ) u_cmp (
    .ctrl(ctrl),
    .cur_row(cur_row),
    .cand_row(rd_row),
    .dominates(cmp_dom)
  );

  assign hit = pend && (j_prev != i_idx) && cmp_dom;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      point_count  <= '0;
      dropped_flag <= 1'b0;
      i_idx        <= '0;
      j_idx        <= '0;
      j_prev       <= '0;
      pend         <= 1'b0;
      cur_load     <= 1'b0;
      dom          <= 1'b0;
      keep         <= '0;
      last_kept    <= '0;
      out_valid    <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_beat) begin
            if (wr_en) begin
              point_count <= point_count + CNT_W'(1);
            end else begin
              dropped_flag <= 1'b1;
            end
            if (s_tlast) begin
              i_idx <= '0;
              state <= ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          dom      <= 1'b0;
          pend     <= 1'b0;
          j_idx    <= '0;
          cur_load <= 1'b1;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          if (cur_load) begin
            cur_row  <= rd_row;
            cur_load <= 1'b0;
          end
          dom    <= dom | hit;
          pend   <= 1'b1;
          j_prev <= j_idx;
          if (CNT_W'(j_idx) == last_idx) begin
            state <= ST_DRAIN;
          end else begin
            j_idx <= j_idx + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          keep[i_idx] <= !(dom | hit);
          if (!(dom | hit)) begin
            last_kept <= i_idx;
          end
          if (CNT_W'(i_idx) == last_idx) begin
            i_idx <= '0;
            state <= ST_EMIT_FETCH;
          end else begin
            i_idx <= i_idx + IDX_W'(1);
            state <= ST_FETCH;
          end
        end
        ST_EMIT_FETCH: begin
          // a strict order always leaves one kept point, so this stops
          if (keep[i_idx]) begin
            state <= ST_EMIT_LOAD;
          end else begin
            i_idx <= i_idx + IDX_W'(1);
          end
        end
        ST_EMIT_LOAD: begin
          out_row   <= rd_row;
          out_index <= INDEX_W'(i_idx);
          out_last  <= (i_idx == last_kept);
          out_ovf   <= dropped_flag;
          out_valid <= 1'b1;
          state     <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          if (out_beat) begin
            out_valid <= 1'b0;
            if (out_last) begin
              point_count  <= '0;
              dropped_flag <= 1'b0;
              keep         <= '0;
              state        <= ST_LOAD;
            end else begin
              i_idx <= i_idx + IDX_W'(1);
              state <= ST_EMIT_FETCH;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // output beat, values sign-extended to the field width
  always_comb begin
    m_tdata = '0;
    m_tdata[INDEX_W-1:0] = out_index;
    for (int k = 0; k < MAX_OBJECTIVES; k++) begin
      m_tdata[INDEX_W + k*FIELD_W +: FIELD_W] = FIELD_W'($signed(out_row[k*VB +: VB]));
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tuser  = out_ovf;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_busy_after_close: assert property (@(posedge clk) disable iff (rst)
    in_beat && s_tlast |=> !s_tready)
    else $error("input taken while filtering");

  a_emit_kept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> keep[i_idx])
    else $error("emitting a dominated point");

  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    out_beat && m_tlast |=> point_count == '0 && !dropped_flag)
    else $error("store not emptied after final result");

endmodule
